// ===== sv/rcrt_pkg.sv =====
`default_nettype none

package rcrt_pkg;

  localparam int INDEX_W     = 8;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 9;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS_IN_USE = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  typedef enum logic [1:0] {
    KIND_LOAD      = 2'd0,
    KIND_SWAP_ROWS = 2'd1,
    KIND_SWAP_COLS = 2'd2,
    KIND_GET       = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [INDEX_W-1:0]  first_index;
    logic [INDEX_W-1:0]  second_index;
    logic [DATA_W-1:0]   cell_value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              out_of_range;
  } rsp_t;

endpackage

`default_nettype wire

// ===== sv/rcrt_ram.sv =====
`default_nettype none

module rcrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== sv/row_column_remap_table_unit.sv =====
`default_nettype none

// Row/column remapped value store. Cells live in a ROWS x COLS RAM. Gets
// reach them through a row map RAM and a column map RAM; loads write the
// cell at the raw indices. Both maps are loaded with the identity by a sweep
// over max(ROWS, COLS) entries after reset, during which req_ready stays low
// (cfg writes are taken at any time). A load or an ignored (out of range)
// load or swap stays in idle. A swap reads both map entries, then does one
// write per entry through the map RAM's single write port. A get passes map
// read, cell read and result register; a get with an out of range index
// skips the cell read. A get also waits while the previous response sits
// unaccepted in the output register. Counts above ROWS/COLS act as ROWS/COLS.
module row_column_remap_table_unit
  import rcrt_pkg::*;
#(
  parameter int ROWS        = 256,
  parameter int COLS        = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output logic                        req_ready,
  input  wire req_t                   req,
  output logic                        rsp_valid,
  input  wire logic                   rsp_ready,
  output rsp_t                        rsp,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]     cfg_data
);

  localparam int RW   = $clog2(ROWS);
  localparam int CLW  = $clog2(COLS);
  localparam int CA   = $clog2(ROWS * COLS);
  localparam int MAXD = (ROWS > COLS) ? ROWS : COLS;
  localparam int IW   = $clog2(MAXD);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_GET_MAP,
    ST_RESULT
  } state_t;

  state_t               state;
  req_t                 cur;
  logic                 cur_oor;
  logic [IW-1:0]        init_cnt;
  logic [COUNT_W-1:0]   rows_in_use;
  logic [COUNT_W-1:0]   cols_in_use;
  logic [RW-1:0]        row_tmp;
  logic [CLW-1:0]       col_tmp;

  logic                 req_fire;
  logic [INDEX_W-1:0]   rd_first;
  logic [INDEX_W-1:0]   rd_second;
  logic                 first_row_ok;
  logic                 second_row_ok;
  logic                 first_col_ok;
  logic                 second_col_ok;

  logic                 row_we;
  logic [RW-1:0]        row_waddr;
  logic [RW-1:0]        row_wdata;
  logic [RW-1:0]        row_rd_a;
  logic [RW-1:0]        row_rd_b;
  logic                 col_we;
  logic [CLW-1:0]       col_waddr;
  logic [CLW-1:0]       col_wdata;
  logic [CLW-1:0]       col_rd_a;
  logic [CLW-1:0]       col_rd_b;

  logic                 cell_we;
  logic [CA-1:0]        cell_waddr;
  logic [VALUE_WIDTH-1:0] cell_wdata;
  logic [CA-1:0]        cell_raddr;
  logic [VALUE_WIDTH-1:0] cell_rdata;
  logic [63:0]          value_wide;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  assign first_row_ok  = (11'(req.first_index) < 11'(ROWS)) &&
                         ({1'b0, req.first_index} < rows_in_use);
  assign second_row_ok = (11'(req.second_index) < 11'(ROWS)) &&
                         ({1'b0, req.second_index} < rows_in_use);
  assign first_col_ok  = (11'(req.first_index) < 11'(COLS)) &&
                         ({1'b0, req.first_index} < cols_in_use);
  assign second_col_ok = (11'(req.second_index) < 11'(COLS)) &&
                         ({1'b0, req.second_index} < cols_in_use);

  // map reads: from the port while idle, from the held request afterwards
  assign rd_first  = (state == ST_IDLE) ? req.first_index  : cur.first_index;
  assign rd_second = (state == ST_IDLE) ? req.second_index : cur.second_index;

  always_comb begin
    row_we    = 1'b0;
    row_waddr = RW'(init_cnt);
    row_wdata = RW'(init_cnt);
    col_we    = 1'b0;
    col_waddr = CLW'(init_cnt);
    col_wdata = CLW'(init_cnt);
    unique case (state)
      ST_INIT: begin
        row_we = (11'(init_cnt) < 11'(ROWS));
        col_we = (11'(init_cnt) < 11'(COLS));
      end
      ST_SWAP_A: begin
        row_we    = (cur.kind == KIND_SWAP_ROWS);
        row_waddr = RW'(cur.first_index);
        row_wdata = row_rd_b;
        col_we    = (cur.kind == KIND_SWAP_COLS);
        col_waddr = CLW'(cur.first_index);
        col_wdata = col_rd_b;
      end
      ST_SWAP_B: begin
        row_we    = (cur.kind == KIND_SWAP_ROWS);
        row_waddr = RW'(cur.second_index);
        row_wdata = row_tmp;
        col_we    = (cur.kind == KIND_SWAP_COLS);
        col_waddr = CLW'(cur.second_index);
        col_wdata = col_tmp;
      end
      ST_IDLE, ST_GET_MAP, ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  assign cell_we    = req_fire && (req.kind == KIND_LOAD) && first_row_ok && second_col_ok;
  assign cell_waddr = CA'(32'(req.first_index) * COLS + 32'(req.second_index));
  assign cell_wdata = VALUE_WIDTH'(req.cell_value);
  assign cell_raddr = CA'(32'(row_rd_a) * COLS + 32'(col_rd_b));
  assign value_wide = 64'(cell_rdata);

  rcrt_ram #(.WIDTH(RW), .DEPTH(ROWS)) u_row_map (
    .clk     (clk),
    .we      (row_we),
    .waddr   (row_waddr),
    .wdata   (row_wdata),
    .raddr_a (RW'(rd_first)),
    .rdata_a (row_rd_a),
    .raddr_b (RW'(rd_second)),
    .rdata_b (row_rd_b)
  );

  rcrt_ram #(.WIDTH(CLW), .DEPTH(COLS)) u_col_map (
    .clk     (clk),
    .we      (col_we),
    .waddr   (col_waddr),
    .wdata   (col_wdata),
    .raddr_a (CLW'(rd_first)),
    .rdata_a (col_rd_a),
    .raddr_b (CLW'(rd_second)),
    .rdata_b (col_rd_b)
  );

  rcrt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(ROWS * COLS)) u_cells (
    .clk     (clk),
    .we      (cell_we),
    .waddr   (cell_waddr),
    .wdata   (cell_wdata),
    .raddr_a (cell_raddr),
    .rdata_a (cell_rdata),
    .raddr_b (cell_raddr),
    .rdata_b ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      init_cnt    <= '0;
      rsp_valid   <= 1'b0;
      rows_in_use <= COUNT_RESET;
      cols_in_use <= COUNT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROWS_IN_USE) begin
          rows_in_use <= cfg_data;
        end else if (cfg_index == REG_COLS_IN_USE) begin
          cols_in_use <= cfg_data;
        end
      end

      if (rsp_valid && rsp_ready && (state != ST_RESULT)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == IW'(MAXD - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            cur <= req;
            unique case (req.kind)
              KIND_LOAD: begin
              end
              KIND_SWAP_ROWS: begin
                if (first_row_ok && second_row_ok) begin
                  state <= ST_SWAP_A;
                end
              end
              KIND_SWAP_COLS: begin
                if (first_col_ok && second_col_ok) begin
                  state <= ST_SWAP_A;
                end
              end
              KIND_GET: begin
                cur_oor <= !(first_row_ok && second_col_ok);
                state   <= (first_row_ok && second_col_ok) ? ST_GET_MAP : ST_RESULT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SWAP_A: begin
          row_tmp <= row_rd_a;
          col_tmp <= col_rd_a;
          state   <= ST_SWAP_B;
        end
        ST_SWAP_B: begin
          state <= ST_IDLE;
        end
        ST_GET_MAP: begin
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid        <= 1'b1;
            rsp.read_value   <= cur_oor ? '0 : value_wide[DATA_W-1:0];
            rsp.out_of_range <= cur_oor;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.out_of_range |-> rsp.read_value == '0)
    else $error("out of range response carries a value");

  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_RESULT)
    else $error("response raised outside result state");

  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWAP_B |-> $past(state) == ST_SWAP_A)
    else $error("second swap write without first");

  a_no_req_in_init: assert property (@(posedge clk) disable iff (rst)
    state == ST_INIT |-> !cell_we)
    else $error("cell write during map init");

endmodule

`default_nettype wire
